>>> hdl/upe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent encoder package
// Shared types, register indexes, reset values and the hex digit helper.
// ----------------------------------------------------------------------------
package upe_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WORD0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD3 = 2'd3;

  // Reset loads the URI unescaped set.
  localparam logic [CFG_DATA_W-1:0] WORD0_RST = 32'h0000_0000;
  localparam logic [CFG_DATA_W-1:0] WORD1_RST = 32'hAFFF_FFDA;
  localparam logic [CFG_DATA_W-1:0] WORD2_RST = 32'h87FF_FFFF;
  localparam logic [CFG_DATA_W-1:0] WORD3_RST = 32'h47FF_FFFE;

  localparam logic [7:0] SURROGATE_LEAD = 8'hED;
  localparam logic [7:0] CHAR_PERCENT   = 8'h25;

  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_ESC  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    BEAT_PCT = 2'd0,
    BEAT_HI  = 2'd1,
    BEAT_LO  = 2'd2
  } beat_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  function automatic logic [7:0] nibble_to_ascii(input logic [3:0] v);
    logic [7:0] w;
    w = {4'b0000, v};
    if (v > 4'd9) begin
      return w + 8'd55;
    end
    return w + 8'd48;
  endfunction

endpackage

>>> hdl/upe_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent encoder stream interfaces
// Valid/ready channels for input bytes and encoded result characters.
// ----------------------------------------------------------------------------
interface upe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in_string;

  modport source (output valid, output in_byte, output last_in_string, input ready);
  modport sink   (input valid, input in_byte, input last_in_string, output ready);
endinterface

interface upe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       string_end;
  logic       error_flag;

  modport source (output valid, output out_byte, output last_of_run,
                  output string_end, output error_flag, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input string_end, input error_flag, output ready);
endinterface

>>> hdl/uri_percent_encoder.sv
// An accepted request is written into the queue and from there loaded into the output register.
// Throughput: one input byte per cycle while the queue has room; a passed or error byte gives
// one result character, an escaped byte three, all through the single output register.
// A queue of QUEUE_DEPTH requests lets the input keep flowing while escapes are emitted.
// Reset (rst_n, synchronous) empties the queue, clears surrogate tracking and loads the URI set.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent encoder
// Percent-encodes a UTF-8 byte stream against a loadable 128-bit unescaped set.
// ----------------------------------------------------------------------------
module uri_percent_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [upe_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [upe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  upe_in_if.sink                         in_ch,
  upe_out_if.source                      out_ch
);
  import upe_pkg::*;

  // The front end classifies each accepted byte as pass-through, escape or
  // error, and keeps the surrogate state: a lead flag and a per-string error latch.
  logic   push;
  logic   q_full;
  entry_t push_entry;

  // The back end drains the queue, emitting three result characters for an escape.
  logic   pop;
  logic   q_valid;
  entry_t head;

  upe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.in_byte),
    .in_last    (in_ch.last_in_string),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  // Requests wait here so that the input side stalls only once the queue
  // has filled behind a run of escaped bytes.
  upe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  // Results leave through a register; a new one loads whenever the current
  // one is taken or the register is empty.
  upe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_byte        (out_ch.out_byte),
    .out_last_of_run (out_ch.last_of_run),
    .out_string_end  (out_ch.string_end),
    .out_error_flag  (out_ch.error_flag)
  );

endmodule

>>> hdl/upe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent encoder front end
// Holds the unescaped set, tracks surrogate state and classifies each byte.
// ----------------------------------------------------------------------------
module upe_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [upe_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [upe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  input  logic                           in_last,
  output logic                           push,
  output upe_pkg::entry_t                push_entry,
  input  logic                           q_full
);
  import upe_pkg::*;

  logic [3:0][CFG_DATA_W-1:0] word_r;
  logic after_lead_r, after_lead_nxt;
  logic err_latched_r, err_latched_nxt;
  logic err_now;
  logic unesc;
  logic [CFG_DATA_W-1:0] sel_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r[0] <= WORD0_RST;
      word_r[1] <= WORD1_RST;
      word_r[2] <= WORD2_RST;
      word_r[3] <= WORD3_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WORD0: word_r[0] <= cfg_wdata;
        CFG_WORD1: word_r[1] <= cfg_wdata;
        CFG_WORD2: word_r[2] <= cfg_wdata;
        CFG_WORD3: word_r[3] <= cfg_wdata;
        default:   word_r[0] <= word_r[0];
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  assign sel_word = word_r[in_byte[6:5]];
  assign unesc    = !in_byte[7] && sel_word[in_byte[4:0]];
  assign err_now  = err_latched_r || (after_lead_r && in_byte[5]);

  always_comb begin
    push_entry.data = in_byte;
    push_entry.last = in_last;
    if (err_now) begin
      push_entry.kind = KIND_ERR;
    end else if (unesc) begin
      push_entry.kind = KIND_PASS;
    end else begin
      push_entry.kind = KIND_ESC;
    end

    after_lead_nxt  = after_lead_r;
    err_latched_nxt = err_latched_r;
    if (push) begin
      if (in_last) begin
        after_lead_nxt  = 1'b0;
        err_latched_nxt = 1'b0;
      end else begin
        err_latched_nxt = err_now;
        after_lead_nxt  = !err_now && !after_lead_r && (in_byte == SURROGATE_LEAD);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_lead_r  <= 1'b0;
      err_latched_r <= 1'b0;
    end else begin
      after_lead_r  <= after_lead_nxt;
      err_latched_r <= err_latched_nxt;
    end
  end

endmodule

>>> hdl/upe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent encoder request queue
// Small flop-based FIFO of classified requests between front and back end.
// ----------------------------------------------------------------------------
module upe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  upe_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output upe_pkg::entry_t head
);
  import upe_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t            mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> hdl/upe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent encoder back end
// Expands each request into one or three result characters.
// ----------------------------------------------------------------------------
module upe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  upe_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run,
  output logic            out_string_end,
  output logic            out_error_flag
);
  import upe_pkg::*;

  beat_t      beat_r, beat_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       run_end_r, run_end_nxt;
  logic       str_end_r, str_end_nxt;
  logic       err_r, err_nxt;
  logic       load;
  logic       final_beat;

  assign load = !valid_r || out_ready;

  always_comb begin
    final_beat  = (head.kind != KIND_ESC) || (beat_r == BEAT_LO);
    pop         = load && q_valid && final_beat;
    valid_nxt   = valid_r;
    beat_nxt    = beat_r;
    byte_nxt    = byte_r;
    run_end_nxt = run_end_r;
    str_end_nxt = str_end_r;
    err_nxt     = err_r;
    if (load) begin
      valid_nxt = q_valid;
      if (q_valid) begin
        run_end_nxt = final_beat;
        str_end_nxt = final_beat && head.last;
        err_nxt     = 1'b0;
        case (head.kind)
          KIND_PASS: byte_nxt = head.data;
          KIND_ERR: begin
            byte_nxt = 8'h00;
            err_nxt  = 1'b1;
          end
          default: begin
            case (beat_r)
              BEAT_PCT: byte_nxt = CHAR_PERCENT;
              BEAT_HI:  byte_nxt = nibble_to_ascii(head.data[7:4]);
              default:  byte_nxt = nibble_to_ascii(head.data[3:0]);
            endcase
          end
        endcase
        if (final_beat) begin
          beat_nxt = BEAT_PCT;
        end else if (beat_r == BEAT_PCT) begin
          beat_nxt = BEAT_HI;
        end else begin
          beat_nxt = BEAT_LO;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= BEAT_PCT;
    end else begin
      valid_r <= valid_nxt;
      beat_r  <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    run_end_r <= run_end_nxt;
    str_end_r <= str_end_nxt;
    err_r     <= err_nxt;
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = run_end_r;
  assign out_string_end  = str_end_r;
  assign out_error_flag  = err_r;

endmodule

>>> tb/sv/uri_percent_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent encoder testbench
// Drives byte strings through the encoder under several unescaped sets and
// handshake patterns, predicts every encoded character and checks each one.
// ----------------------------------------------------------------------------
module uri_percent_encoder_tb;
  import upe_pkg::CFG_IDX_W;
  import upe_pkg::CFG_DATA_W;
  import upe_pkg::CFG_WORD0;
  import upe_pkg::CFG_WORD1;
  import upe_pkg::CFG_WORD2;
  import upe_pkg::CFG_WORD3;
  import upe_pkg::WORD0_RST;
  import upe_pkg::WORD1_RST;
  import upe_pkg::WORD2_RST;
  import upe_pkg::WORD3_RST;
  import upe_pkg::SURROGATE_LEAD;
  import upe_pkg::CHAR_PERCENT;

  // Generous bound on the whole run; the slowest legal run needs a small
  // fraction of this even with every byte escaped and heavy stalling.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned PHASE_ITEMS   = 60;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam logic [7:0]  SURROGATE_BIT = 8'h20;

  // One input request: a byte and its end-of-string marker.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  // One encoded character as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       str_end;
    logic       err;
  } enc_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  upe_in_if  in_ch ();
  upe_out_if out_ch ();

  uri_percent_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Requests waiting to be offered, and characters waiting to be seen.
  byte_req_t pending_q[$];
  enc_char_t encoded_q[$];

  // Our own copy of the unescaped set and the surrogate tracking state.
  logic [31:0] unescaped_set [4];
  logic        after_lead;
  logic        err_latched;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.in_byte        = 8'h00;
    in_ch.last_in_string = 1'b0;
    out_ch.ready         = 1'b0;
    unescaped_set[CFG_WORD0] = WORD0_RST;
    unescaped_set[CFG_WORD1] = WORD1_RST;
    unescaped_set[CFG_WORD2] = WORD2_RST;
    unescaped_set[CFG_WORD3] = WORD3_RST;
    after_lead  = 1'b0;
    err_latched = 1'b0;
  end

  initial begin
    forever #5 clk = ~clk;
  end

  // Upper-case ASCII hex digit of the low nibble.
  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    return (nib > 4'd9) ? ({4'h0, nib} + 8'h37) : ({4'h0, nib} + 8'h30);
  endfunction

  // Works out the characters one accepted request must produce and appends
  // them to the queue of expected characters, advancing the surrogate state.
  function automatic void predict_encoding(input byte_req_t req);
    logic passes;
    passes = (req.data[7] == 1'b0) && unescaped_set[req.data[6:5]][req.data[4:0]];
    // Only the byte straight after a 0xED lead is inspected for the
    // surrogate bit; once latched, the rest of the string is all errors.
    if (!err_latched && after_lead && ((req.data & SURROGATE_BIT) != 8'h00)) begin
      err_latched = 1'b1;
    end
    if (err_latched) begin
      encoded_q.push_back('{data: 8'h00, run_end: 1'b1, str_end: req.last, err: 1'b1});
      after_lead = 1'b0;
    end else begin
      if (passes) begin
        encoded_q.push_back('{data: req.data, run_end: 1'b1, str_end: req.last, err: 1'b0});
      end else begin
        encoded_q.push_back('{data: CHAR_PERCENT, run_end: 1'b0, str_end: 1'b0, err: 1'b0});
        encoded_q.push_back('{data: ascii_hex(req.data[7:4]), run_end: 1'b0, str_end: 1'b0,
                              err: 1'b0});
        encoded_q.push_back('{data: ascii_hex(req.data[3:0]), run_end: 1'b1,
                              str_end: req.last, err: 1'b0});
      end
      after_lead = !after_lead && (req.data == SURROGATE_LEAD);
    end
    // A new string always starts with clean surrogate tracking.
    if (req.last) begin
      after_lead  = 1'b0;
      err_latched = 1'b0;
    end
  endfunction

  // Request driver. The byte on the channel is always the head of the
  // pending queue; it is removed and predicted once the handshake completes.
  always @(posedge clk) begin : drive_requests
    bit accepted;
    bit idle_now;
    accepted = in_ch.valid && in_ch.ready;
    idle_now = (send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct);
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (accepted) begin
        predict_encoding(pending_q[0]);
        void'(pending_q.pop_front());
      end
      if (in_ch.valid && !accepted) begin
        // An offered request stays on the channel until it is taken.
      end else if (pending_q.size() != 0 && !idle_now) begin
        in_ch.valid          <= 1'b1;
        in_ch.in_byte        <= pending_q[0].data;
        in_ch.last_in_string <= pending_q[0].last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so that the ready logic only has to
  // look at whether the count has run out.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: every accepted character is matched against the oldest
  // expectation. Ready is lowered at random and during the hold-off.
  always @(posedge clk) begin : check_results
    enc_char_t got;
    enc_char_t want;
    got = '{data: out_ch.out_byte, run_end: out_ch.last_of_run,
            str_end: out_ch.string_end, err: out_ch.error_flag};
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (encoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: unexpected character data=%02h run_end=%0b str_end=%0b err=%0b",
                     $time, got.data, got.run_end, got.str_end, got.err);
          end
        end else begin
          want = encoded_q.pop_front();
          if (got.data !== want.data || got.run_end !== want.run_end ||
              got.str_end !== want.str_end || got.err !== want.err) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: mismatch expected data=%02h run_end=%0b str_end=%0b err=%0b",
                       $time, want.data, want.run_end, want.str_end, want.err);
              $display("%0t:          actual   data=%02h run_end=%0b str_end=%0b err=%0b",
                       $time, got.data, got.run_end, got.str_end, got.err);
            end
          end
        end
      end
      out_ch.ready <= (hold_left == 0) &&
                      ((recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct));
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void push_request(input logic [7:0] data, input logic last);
    pending_q.push_back('{data: data, last: last});
  endfunction

  // Builds one random string. Most of its content is plain ASCII or a 0xED
  // lead with a continuation byte, so that surrogate detection is reached
  // often; the rest is arbitrary bytes, stray leads and stray continuations.
  function automatic int unsigned queue_random_string(input int unsigned len);
    int unsigned pos;
    int unsigned pick;
    pos = 0;
    while (pos < len) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        push_request(8'($urandom_range(127)), pos == len - 1);
        pos++;
      end else if (pick < 55) begin
        push_request(8'($urandom_range(255)), pos == len - 1);
        pos++;
      end else if (pick < 78 && pos + 1 < len) begin
        push_request(SURROGATE_LEAD, 1'b0);
        push_request(8'($urandom_range(8'hBF, 8'h80)), pos + 1 == len - 1);
        pos += 2;
      end else if (pick < 88) begin
        push_request(SURROGATE_LEAD, pos == len - 1);
        pos++;
      end else begin
        push_request(8'($urandom_range(8'hBF, 8'h80)), pos == len - 1);
        pos++;
      end
    end
    return len;
  endfunction

  // Fills the pending queue with random strings until a phase's worth of
  // requests has been queued.
  task automatic queue_random_phase();
    int unsigned queued;
    queued = 0;
    while (queued < PHASE_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        queued += queue_random_string(1);
      end else begin
        queued += queue_random_string($urandom_range(9, 2));
      end
    end
  endtask

  // Sender pause: nothing new is offered until every request has been taken
  // and every expected character has come back.
  task automatic wait_drained();
    while (pending_q.size() != 0 || encoded_q.size() != 0 || in_ch.valid) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // Loads all four words of the unescaped set, one write per cycle. Only
  // called while the encoder is idle, so our copy may change at once.
  task automatic load_unescaped_set(input logic [31:0] w0, input logic [31:0] w1,
                                    input logic [31:0] w2, input logic [31:0] w3);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= CFG_WORD0; cfg_wdata <= w0;
    @(posedge clk);
    cfg_idx <= CFG_WORD1; cfg_wdata <= w1;
    @(posedge clk);
    cfg_idx <= CFG_WORD2; cfg_wdata <= w2;
    @(posedge clk);
    cfg_idx <= CFG_WORD3; cfg_wdata <= w3;
    @(posedge clk);
    cfg_we <= 1'b0;
    unescaped_set[CFG_WORD0] = w0;
    unescaped_set[CFG_WORD1] = w1;
    unescaped_set[CFG_WORD2] = w2;
    unescaped_set[CFG_WORD3] = w3;
    @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed strings under the reset (URI) set, with no idling.
    // Field extremes, escaped and unescaped characters.
    push_request(8'h00, 1'b0);
    push_request(8'h7F, 1'b0);
    push_request(8'h80, 1'b0);
    push_request(8'hFF, 1'b0);
    push_request(8'h41, 1'b0);
    push_request(8'h61, 1'b0);
    push_request(CHAR_PERCENT, 1'b0);
    push_request(8'h20, 1'b1);
    // Lone surrogate mid-string: the error carries on to the end.
    push_request(SURROGATE_LEAD, 1'b0);
    push_request(8'hA0, 1'b0);
    push_request(8'h80, 1'b0);
    push_request(8'h41, 1'b1);
    // Follower without the surrogate bit is encoded normally.
    push_request(SURROGATE_LEAD, 1'b0);
    push_request(8'h9F, 1'b0);
    push_request(8'h80, 1'b1);
    // Lead followed by a second lead.
    push_request(SURROGATE_LEAD, 1'b0);
    push_request(SURROGATE_LEAD, 1'b0);
    push_request(8'h41, 1'b1);
    // Lead ends the string; the next string starts without a check.
    push_request(SURROGATE_LEAD, 1'b1);
    push_request(8'hA0, 1'b1);
    // Surrogate found on the last byte of a string.
    push_request(SURROGATE_LEAD, 1'b0);
    push_request(8'hBF, 1'b1);
    // Lead whose follower is a plain ASCII byte that passes through.
    push_request(SURROGATE_LEAD, 1'b0);
    push_request(8'h5A, 1'b1);
    wait_drained();

    // Random strings, URI set, no idling. The receiver holds off for a long
    // stretch at the start while requests keep coming, so the input stalls.
    queue_random_phase();
    hold_req = 1'b1;
    @(negedge clk);
    hold_req = 1'b0;
    wait_drained();

    // Component set, sender idling.
    load_unescaped_set(32'h0000_0000, 32'h03FF_6782, 32'h87FF_FFFE, 32'h47FF_FFFE);
    set_idling(53, 0);
    queue_random_phase();
    wait_drained();

    // Empty set: every byte not flagged as an error is escaped. Receiver stalling.
    load_unescaped_set(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    set_idling(0, 53);
    queue_random_phase();
    wait_drained();

    // Full set: every ASCII byte not flagged as an error passes through. Both sides idling.
    load_unescaped_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_idling(36, 36);
    queue_random_phase();
    wait_drained();

    // Random set, sender idling.
    load_unescaped_set($urandom, $urandom, $urandom, $urandom);
    set_idling(36, 0);
    queue_random_phase();
    wait_drained();

    // Let any stray character show up before the verdict.
    repeat (10) @(negedge clk);
    if (mismatches == 0 && encoded_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
